// File: design/ptmr_pkg.sv
// ----------------------------------------------------------------------------
// ptmr_pkg
// Shared types, constants and helpers for the particle timestep minimum block.
// ----------------------------------------------------------------------------
package ptmr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 20;

  localparam int unsigned COMP_W  = 32;
  localparam int unsigned STEP_W  = 48;
  localparam int unsigned AXIS_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 2'd3;

  localparam logic [COMP_W-1:0] CELL_WIDTH_RST = 32'h0010_0000;
  localparam logic [STEP_W-1:0] STEP_MAX       = '1;

  // |x| of a two's complement component, floored at one LSB
  function automatic logic [COMP_W-1:0] mag32(input logic [COMP_W-1:0] x);
    logic [COMP_W-1:0] m;
    m = x[COMP_W-1] ? (~x + COMP_W'(1)) : x;
    if (m == '0) begin
      m = COMP_W'(1);
    end
    return m;
  endfunction

endpackage

// File: design/ptmr_in_if.sv
// ----------------------------------------------------------------------------
// ptmr_in_if
// Input channel: one axis component of one particle per transaction.
// ----------------------------------------------------------------------------
interface ptmr_in_if import ptmr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [AXIS_W-1:0]        axis;
  logic signed [COMP_W-1:0] velocity;
  logic signed [COMP_W-1:0] accel;
  logic                     restart;

  modport source (output valid, axis, velocity, accel, restart, input ready);
  modport sink   (input valid, axis, velocity, accel, restart, output ready);
endinterface

// File: design/ptmr_out_if.sv
// ----------------------------------------------------------------------------
// ptmr_out_if
// Output channel: running minimum timestep per transaction.
// ----------------------------------------------------------------------------
interface ptmr_out_if import ptmr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_min;
  logic              saturated;

  modport source (output valid, step_min, saturated, input ready);
  modport sink   (input valid, step_min, saturated, output ready);
endinterface

// File: design/particle_timestep_min_reduce.sv
// ----------------------------------------------------------------------------
// particle_timestep_min_reduce
// Running minimum of the velocity (h/|v|) and acceleration (sqrt(2h/|a|))
// timestep limits, one axis component per transaction, Q(48-FRAC_BITS).FRAC_BITS result.
// ----------------------------------------------------------------------------
// An item runs the velocity divide, its minimum update, the acceleration
// divide, the square root, its minimum update and the write state in turn;
// an item on axis three goes straight to the write state. Both divides and
// the square root run through one shared subtract/compare unit that retires
// one quotient bit per cycle for the two restoring divides and one root bit
// per cycle for the square root. A new item is accepted once the previous
// one has reached the output register; the result waits there while the
// next item runs. max_step is read only on restart.
module particle_timestep_min_reduce import ptmr_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ptmr_in_if.sink               in_ch,
  ptmr_out_if.source            out_ch
);

  localparam int unsigned DW     = 33 + FRAC_BITS;
  localparam int unsigned QW     = (DW > STEP_W) ? DW : STEP_W;
  localparam int unsigned RPAIRS = (DW + FRAC_BITS + 1) / 2;
  localparam int unsigned RW2    = 2 * RPAIRS;
  localparam int unsigned RTW    = (RPAIRS > STEP_W) ? RPAIRS : STEP_W;
  localparam int unsigned SW     = RTW + 2;
  localparam int unsigned CW     = $clog2(DW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIVV  = 3'd1;
  localparam logic [2:0] ST_MINV  = 3'd2;
  localparam logic [2:0] ST_DIVA  = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_MINA  = 3'd5;
  localparam logic [2:0] ST_WRITE = 3'd6;

  logic [COMP_W-1:0] cell_width_x, cell_width_y, cell_width_z;
  logic [STEP_W-1:0] max_step;
  logic [STEP_W-1:0] running_min;

  logic [2:0]        state;
  logic [CW-1:0]     cnt;
  logic [COMP_W-1:0] h_reg;
  logic [COMP_W-1:0] ma_reg;
  logic [COMP_W-1:0] divisor;
  logic [DW-1:0]     dvd;
  logic [QW-1:0]     quo;
  logic [RW2-1:0]    rad;
  logic [RTW-1:0]    root;
  logic [SW-1:0]     rem;
  logic              sat;

  logic              out_valid;
  logic [STEP_W-1:0] out_step;
  logic              out_sat;

  logic              in_acc;
  logic [COMP_W-1:0] h_sel;

  logic [SW-1:0]     sub_a, sub_b;
  logic [SW:0]       diff;
  logic              ge;
  logic [QW-1:0]     quo_next;
  logic [RTW-1:0]    root_next;
  logic [SW-1:0]     rem_next;

  logic              lim_big;
  logic [STEP_W-1:0] lim;

  assign in_ch.ready     = (state == ST_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.step_min = out_step;
  assign out_ch.saturated = out_sat;

  always_comb begin
    case (in_ch.axis)
      AXIS_X:  h_sel = cell_width_x;
      AXIS_Y:  h_sel = cell_width_y;
      default: h_sel = cell_width_z;
    endcase
  end

  // shared subtract/compare unit
  always_comb begin
    if (state == ST_SQRT) begin
      sub_a = {rem[SW-3:0], rad[RW2-1 -: 2]};
      sub_b = {root, 2'b01};
    end else begin
      sub_a = {rem[SW-2:0], dvd[DW-1]};
      sub_b = SW'(divisor);
    end
    diff      = {1'b0, sub_a} - {1'b0, sub_b};
    ge        = !diff[SW];
    rem_next  = ge ? diff[SW-1:0] : sub_a;
    quo_next  = {quo[QW-2:0], ge};
    root_next = {root[RTW-2:0], ge};
  end

  always_comb begin
    if (state == ST_MINA) begin
      lim_big = (root >> STEP_W) != '0;
      lim     = lim_big ? STEP_MAX : root[STEP_W-1:0];
    end else begin
      lim_big = (quo >> STEP_W) != '0;
      lim     = lim_big ? STEP_MAX : quo[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width_x <= CELL_WIDTH_RST;
      cell_width_y <= CELL_WIDTH_RST;
      cell_width_z <= CELL_WIDTH_RST;
      max_step     <= STEP_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_WIDTH_X: cell_width_x <= cfg_data[COMP_W-1:0];
        REG_CELL_WIDTH_Y: cell_width_y <= cfg_data[COMP_W-1:0];
        REG_CELL_WIDTH_Z: cell_width_z <= cfg_data[COMP_W-1:0];
        REG_MAX_STEP:     max_step     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_min <= STEP_MAX;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_WRITE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.restart) begin
              running_min <= max_step;
            end
            sat     <= 1'b0;
            h_reg   <= h_sel;
            ma_reg  <= mag32(in_ch.accel);
            divisor <= mag32(in_ch.velocity);
            dvd     <= DW'(h_sel) << FRAC_BITS;
            rem     <= '0;
            quo     <= '0;
            cnt     <= CW'(DW - 1);
            state   <= (in_ch.axis == AXIS_NONE) ? ST_WRITE : ST_DIVV;
          end
        end
        ST_DIVV, ST_DIVA: begin
          quo <= quo_next;
          dvd <= dvd << 1;
          if (cnt != '0) begin
            rem <= rem_next;
            cnt <= cnt - CW'(1);
          end else if (state == ST_DIVV) begin
            state <= ST_MINV;
          end else begin
            rad   <= RW2'(quo_next[DW-1:0]) << FRAC_BITS;
            root  <= '0;
            rem   <= '0;
            cnt   <= CW'(RPAIRS - 1);
            state <= ST_SQRT;
          end
        end
        ST_MINV: begin
          if (lim < running_min) begin
            running_min <= lim;
          end
          sat     <= sat | lim_big;
          divisor <= ma_reg;
          dvd     <= DW'(h_reg) << (FRAC_BITS + 1);
          rem     <= '0;
          quo     <= '0;
          cnt     <= CW'(DW - 1);
          state   <= ST_DIVA;
        end
        ST_SQRT: begin
          rem  <= rem_next;
          root <= root_next;
          rad  <= rad << 2;
          cnt  <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= ST_MINA;
          end
        end
        ST_MINA: begin
          if (lim < running_min) begin
            running_min <= lim;
          end
          sat   <= sat | lim_big;
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (!out_valid || out_ch.ready) begin
            out_step  <= running_min;
            out_sat   <= sat;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_min_monotone: assert property (@(posedge clk) disable iff (rst)
    !(in_acc && in_ch.restart) |=> running_min <= $past(running_min))
    else $error("running minimum rose without restart");

  a_out_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_WRITE))
    else $error("result loaded outside write state");

  a_axis_none: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.axis == AXIS_NONE) |=> (state == ST_WRITE && !sat))
    else $error("axis three item not bypassed");
`endif

endmodule
